### rtl/optimal_fscore_threshold_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the F-score threshold core
// Clocked implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_FSCORE_THRESHOLD_CORE_ASSERT_SVH
`define OPTIMAL_FSCORE_THRESHOLD_CORE_ASSERT_SVH

// same-cycle implication
`define OFSC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OFSC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ofsc_pkg.sv
// ----------------------------------------------------------------------------
// ofsc_pkg
// Shared types and codes of the F-score threshold core.
// ----------------------------------------------------------------------------
package ofsc_pkg;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } ofsc_chain_ctrl_t;

  localparam int BETA_W = 16;
  localparam int K_W    = 17;
  localparam logic [BETA_W-1:0] DEFAULT_BETA_SQ = 16'd256;

  localparam logic CFG_BETA_SQ  = 1'b0;
  localparam logic CFG_INIT_THR = 1'b1;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_SHIFT = 3'd1;
  localparam logic [ST_W-1:0] ST_MUL   = 3'd2;
  localparam logic [ST_W-1:0] ST_DEN   = 3'd3;
  localparam logic [ST_W-1:0] ST_GO    = 3'd4;
  localparam logic [ST_W-1:0] ST_WAIT  = 3'd5;
  localparam logic [ST_W-1:0] ST_FIN   = 3'd6;

endpackage

### rtl/ofsc_cell.sv
// ----------------------------------------------------------------------------
// ofsc_cell
// One slot of the sorting chain: keeps its value, yields to an insert, takes its
// neighbor's value on a shift, or is marked empty on a clear.
// ----------------------------------------------------------------------------
module ofsc_cell
  import ofsc_pkg::*;
#(
  parameter int W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ofsc_chain_ctrl_t ctrl,
  input  logic [W-1:0]     p_in,
  input  logic [W-1:0]     prev_val,
  input  logic             prev_valid,
  input  logic             prev_gt,
  input  logic [W-1:0]     next_val,
  input  logic             next_valid,
  output logic [W-1:0]     val,
  output logic             valid,
  output logic             gt
);

  logic [W-1:0] val_r, val_nxt;
  logic         valid_r, valid_nxt;

  assign gt    = !valid_r || (val_r > p_in);
  assign val   = val_r;
  assign valid = valid_r;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      val_nxt   = next_val;
      valid_nxt = next_valid;
    end else if (ctrl.insert && gt) begin
      if (prev_gt) begin
        val_nxt   = prev_val;
        valid_nxt = prev_valid;
      end else begin
        val_nxt   = p_in;
        valid_nxt = 1'b1;
      end
    end
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### rtl/ofsc_sort_chain.sv
// ----------------------------------------------------------------------------
// ofsc_sort_chain
// Row of cells kept in ascending order on insert; shifts toward the head.
// ----------------------------------------------------------------------------
module ofsc_sort_chain
  import ofsc_pkg::*;
#(
  parameter int N = 1024,
  parameter int W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ofsc_chain_ctrl_t ctrl,
  input  logic [W-1:0]     p_in,
  output logic [W-1:0]     head_val,
  output logic             head_valid
);

  logic [W-1:0] val_w   [N];
  logic         valid_w [N];
  logic         gt_w    [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] pv, nv;
    logic         pvld, pgt, nvld;

    if (i == 0) begin : g_first
      assign pv   = '0;
      assign pvld = 1'b0;
      assign pgt  = 1'b0;
    end else begin : g_mid
      assign pv   = val_w[i-1];
      assign pvld = valid_w[i-1];
      assign pgt  = gt_w[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_body
      assign nv   = val_w[i+1];
      assign nvld = valid_w[i+1];
    end

    ofsc_cell #(.W(W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .p_in       (p_in),
      .prev_val   (pv),
      .prev_valid (pvld),
      .prev_gt    (pgt),
      .next_val   (nv),
      .next_valid (nvld),
      .val        (val_w[i]),
      .valid      (valid_w[i]),
      .gt         (gt_w[i])
    );
  end

  assign head_val   = val_w[0];
  assign head_valid = valid_w[0];

endmodule

### rtl/ofsc_ratio_cmp.sv
// ----------------------------------------------------------------------------
// ofsc_ratio_cmp
// Bit-serial cross multiply: tells whether a_num/a_den >= b_num/b_den.
// ----------------------------------------------------------------------------
module ofsc_ratio_cmp #(
  parameter int DW = 45
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] a_num,
  input  logic [DW-1:0] a_den,
  input  logic [DW-1:0] b_num,
  input  logic [DW-1:0] b_den,
  output logic          done,
  output logic          ge
);

  localparam int PWID = 2 * DW;
  localparam int CNTW = $clog2(DW + 1);

  logic [PWID-1:0] mc_l_r, mc_r_r, acc_l_r, acc_r_r;
  logic [DW-1:0]   mp_l_r, mp_r_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_l_r  <= PWID'(a_num);
      mp_l_r  <= b_den;
      mc_r_r  <= PWID'(b_num);
      mp_r_r  <= a_den;
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (busy_r) begin
      if (mp_l_r[0]) acc_l_r <= acc_l_r + mc_l_r;
      if (mp_r_r[0]) acc_r_r <= acc_r_r + mc_r_r;
      mc_l_r <= mc_l_r << 1;
      mc_r_r <= mc_r_r << 1;
      mp_l_r <= mp_l_r >> 1;
      mp_r_r <= mp_r_r >> 1;
    end
  end

  assign done = done_r;
  assign ge   = acc_l_r >= acc_r_r;

endmodule

### rtl/optimal_fscore_threshold_core.sv
// Output: a word without tlast gives its result word in the cycle after accept.
// A word with tlast gives its result after the sort chain is scanned, each held
// word in turn being weighed against the best so far by the bit-serial compare.
// Throughput: one word per cycle while loading and the output is free; no word is taken during a scan.
// Reset: sort chain empty, count and drop flag zero, threshold 0, beta squared 256.
// ----------------------------------------------------------------------------
// optimal_fscore_threshold_core
// Collects probabilities into a sorting chain and picks the best F-beta cut.
// ----------------------------------------------------------------------------
`include "optimal_fscore_threshold_core_assert.svh"

module optimal_fscore_threshold_core
  import ofsc_pkg::*;
#(
  parameter int MAX_ITEMS      = 1024,
  parameter int PROB_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // probability
  input  logic [((PROB_FRAC_BITS+8)/8)*8-1:0] in_tdata,
  input  logic in_tlast,
  input  logic in_tvalid,
  output logic in_tready,
  // threshold, item_count
  output logic [((PROB_FRAC_BITS+1+$clog2(MAX_ITEMS+1)+7)/8)*8-1:0] out_tdata,
  // updated, overflow
  output logic [1:0] out_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [((PROB_FRAC_BITS >= BETA_W) ? PROB_FRAC_BITS : BETA_W - 1):0] cfg_data
);

  localparam int PW     = PROB_FRAC_BITS + 1;
  localparam int CW     = $clog2(MAX_ITEMS + 1);
  localparam int TPW    = $clog2(MAX_ITEMS) + PW;
  localparam int NW     = TPW + K_W;
  localparam int DW     = NW + 1;
  localparam int OUT_DW = ((PW + CW + 7) / 8) * 8;
  localparam logic [PW-1:0] ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

  logic [ST_W-1:0]   state_r;
  logic [BETA_W-1:0] beta_r;
  logic [PW-1:0]     thr_r;
  logic [CW-1:0]     count_r, count_nxt, n_r, idx_r;
  logic              drop_r, drop_nxt, drop_snap_r;
  logic [TPW-1:0]    total_r, tp_r, fp_r;
  logic [PW-1:0]     p_r, best_p_r;
  logic              last_r, best_last_r, found_r;
  logic [NW-1:0]     num_r, bfn_r;
  logic [DW-1:0]     den_r, best_num_r, best_den_r;
  logic [K_W-1:0]    k_w;

  logic [PW-1:0]     out_thr_r;
  logic [CW-1:0]     out_cnt_r;
  logic              out_upd_r, out_ovf_r, out_valid_r, out_valid_nxt;

  logic [PW-1:0]     p_sat, head_val;
  logic              head_valid, room, in_acc, out_free;
  logic              cmp_done, cmp_ge;
  ofsc_chain_ctrl_t  ctrl;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = (state_r == ST_IDLE);
  assign p_sat     = (in_tdata[PW-1:0] > ONE) ? ONE : in_tdata[PW-1:0];
  assign room      = count_r < CW'(MAX_ITEMS);
  assign count_nxt = room ? count_r + 1'b1 : count_r;
  assign drop_nxt  = room ? drop_r : 1'b1;
  assign k_w       = K_W'(beta_r) + K_W'(256);

  assign out_valid_nxt = ((in_acc && !in_tlast) || (state_r == ST_FIN && out_free)) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  assign ctrl.insert = in_acc && room;
  assign ctrl.shift  = (state_r == ST_SHIFT);
  assign ctrl.clear  = (state_r == ST_FIN);

  ofsc_sort_chain #(.N(MAX_ITEMS), .W(PW)) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .p_in       (p_sat),
    .head_val   (head_val),
    .head_valid (head_valid)
  );

  ofsc_ratio_cmp #(.DW(DW)) u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_GO),
    .a_num (DW'(num_r)),
    .a_den (den_r),
    .b_num (best_num_r),
    .b_den (best_den_r),
    .done  (cmp_done),
    .ge    (cmp_ge)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      beta_r      <= DEFAULT_BETA_SQ;
      thr_r       <= '0;
      count_r     <= '0;
      drop_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BETA_SQ:  beta_r <= cfg_data[BETA_W-1:0];
          CFG_INIT_THR: thr_r  <= (cfg_data[PW-1:0] > ONE) ? ONE : cfg_data[PW-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (room) total_r <= total_r + TPW'(ONE - p_sat);
            count_r <= count_nxt;
            drop_r  <= drop_nxt;
            if (in_tlast) begin
              state_r <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_DEN;
        ST_DEN:   state_r <= ST_GO;
        ST_GO:    state_r <= ST_WAIT;
        ST_WAIT: begin
          if (cmp_done) state_r <= last_r ? ST_FIN : ST_SHIFT;
        end
        ST_FIN: begin
          if (out_free) begin
            thr_r       <= !found_r ? '0 : (best_last_r ? ONE : best_p_r);
            count_r     <= '0;
            drop_r      <= 1'b0;
            total_r     <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_thr_r   <= thr_r;
      out_upd_r   <= 1'b0;
      out_cnt_r   <= count_nxt;
      out_ovf_r   <= drop_nxt;
      n_r         <= count_nxt;
      drop_snap_r <= drop_nxt;
      idx_r       <= '0;
      tp_r        <= '0;
      fp_r        <= '0;
      best_num_r  <= '0;
      best_den_r  <= DW'(1);
      found_r     <= 1'b0;
      best_p_r    <= '0;
      best_last_r <= 1'b0;
    end
    if (state_r == ST_SHIFT) begin
      p_r    <= head_val;
      tp_r   <= tp_r + TPW'(ONE - head_val);
      fp_r   <= fp_r + TPW'(head_val);
      last_r <= (CW'(idx_r + 1'b1) == n_r);
      idx_r  <= idx_r + 1'b1;
    end
    if (state_r == ST_MUL) begin
      num_r <= NW'(tp_r) * NW'(k_w);
      bfn_r <= NW'(total_r - tp_r) * NW'(beta_r);
    end
    if (state_r == ST_DEN) begin
      den_r <= DW'(num_r) + DW'(bfn_r) + DW'({fp_r, 8'b0});
    end
    if (state_r == ST_WAIT && cmp_done && den_r != '0 && cmp_ge) begin
      best_num_r  <= DW'(num_r);
      best_den_r  <= den_r;
      best_p_r    <= p_r;
      best_last_r <= last_r;
      found_r     <= 1'b1;
    end
    if (state_r == ST_FIN && out_free) begin
      out_thr_r <= !found_r ? '0 : (best_last_r ? ONE : best_p_r);
      out_upd_r <= 1'b1;
      out_cnt_r <= n_r;
      out_ovf_r <= drop_snap_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_cnt_r, out_thr_r});
  assign out_tuser  = {out_ovf_r, out_upd_r};

  `OFSC_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_ITEMS), "count beyond capacity")
  `OFSC_ASSERT_NXT(a_last_scan, in_acc && in_tlast, state_r == ST_SHIFT, "last word did not start scan")
  `OFSC_ASSERT_IMP(a_head_valid, state_r == ST_SHIFT, head_valid, "scan read an empty chain")
  `OFSC_ASSERT_IMP(a_busy_stall, state_r != ST_IDLE, !in_tready, "word taken during scan")

endmodule
